### hw/rtl/dpu_pkg.sv
// ----------------------------------------------------------------------------
// dpu_pkg
// Shared constants, codes and types of the bitmap pixel unpacker.
// ----------------------------------------------------------------------------
package dpu_pkg;

  // Sizing
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int PAL_DEPTH  = 256;
  localparam int MAX_RUN    = 8;    // most pixels one byte can yield

  localparam int PAL_AW = $clog2(PAL_DEPTH);
  localparam int DIM_W  = 13;                         // width/height registers
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);      // column, holds the width itself
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);     // clamped height
  localparam int ROW_W  = $clog2(MAX_HEIGHT);         // row index
  localparam int RBC_W  = $clog2(MAX_WIDTH * 4 + 4);  // bytes in a padded row
  localparam int CNT_W  = $clog2(MAX_RUN + 1);
  localparam int SLOT_W = $clog2(MAX_RUN);

  // Request commands
  localparam logic [1:0] CMD_DATA    = 2'd0;
  localparam logic [1:0] CMD_PAL     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Pixel modes
  localparam logic [2:0] MODE_1BPP  = 3'd0;
  localparam logic [2:0] MODE_4BPP  = 3'd1;
  localparam logic [2:0] MODE_8BPP  = 3'd2;
  localparam logic [2:0] MODE_24BPP = 3'd3;
  localparam logic [2:0] MODE_32BPP = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [2:0]       MODE_RST   = MODE_24BPP;
  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  // Work handed from the unpacker to the pixel expander
  typedef enum logic [2:0] {
    OP_PIX1,    // 1-bit pixels, byte in data[7:0]
    OP_PIX4,    // 4-bit palette pixels
    OP_PAL8,    // 8-bit palette pixel
    OP_DIRECT,  // finished color in data: bytes {2,1,0} at 32 bpp, {0,1,2} at 24 bpp
    OP_PALWR    // palette write, {R,G,B} in data
  } run_op_t;

  typedef struct packed {
    run_op_t          op;
    logic [CNT_W-1:0] cnt;
    logic [7:0]       pal_idx;
    logic [23:0]      data;
    logic             row_end;
    logic             frame_end;
  } run_t;

  typedef enum logic [1:0] {
    PS_WORD,
    PS_PAL4,
    PS_PAL8
  } pix_sel_t;

endpackage

### hw/rtl/dpu_if.sv
// ----------------------------------------------------------------------------
// dpu_if
// Valid/ready channels of the bitmap pixel unpacker.
// ----------------------------------------------------------------------------
interface dpu_in_if;
  import dpu_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic [7:0] pal_index;
  logic [7:0] pal_blue;
  logic [7:0] pal_green;
  logic [7:0] pal_red;

  modport source (output valid, cmd, data_byte, pal_index, pal_blue, pal_green, pal_red,
                  input ready);
  modport sink (input valid, cmd, data_byte, pal_index, pal_blue, pal_green, pal_red,
                output ready);
endinterface

interface dpu_out_if;
  import dpu_pkg::*;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic        end_of_row;
  logic        end_of_frame;
  logic        last_of_run;

  modport source (output valid, pixel_word, end_of_row, end_of_frame, last_of_run,
                  input ready);
  modport sink (input valid, pixel_word, end_of_row, end_of_frame, last_of_run,
                output ready);
endinterface

interface dpu_cfg_if;
  import dpu_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       index;
  logic [DIM_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/dpu_unpack.sv
// ----------------------------------------------------------------------------
// dpu_unpack
// Config registers, row/frame counters, byte gathering; turns each pixel or
// palette-write request into one run descriptor held in the run register.
// ----------------------------------------------------------------------------
module dpu_unpack (
  input  logic          clk,
  input  logic          rst_n,
  dpu_in_if.sink        in_ch,
  dpu_cfg_if.sink       cfg_ch,
  input  logic          run_take,
  output logic          run_v,
  output dpu_pkg::run_t run
);
  import dpu_pkg::*;

  logic [2:0]       mode_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [RBC_W-1:0] rbc_r, rbc_nxt;
  logic [23:0]      gather_r, gather_nxt;
  logic [1:0]       phase_r, phase_nxt;

  logic             run_v_r;
  run_t             run_r, run_nxt;
  logic             run_ld;
  logic             acc;

  logic [COL_W-1:0] w_eff, left;
  logic [HGT_W-1:0] h_eff;
  logic [RBC_W-1:0] bytes, line_pad, line;
  logic             line_done, last_row;
  logic [1:0]       p_eff;
  logic [23:0]      b_sh, g_new;
  logic [CNT_W-1:0] cnt;

  assign in_ch.ready  = !run_v_r || run_take;
  assign cfg_ch.ready = 1'b1;
  assign acc          = in_ch.valid && in_ch.ready;
  assign run_v        = run_v_r;
  assign run          = run_r;

  // Row geometry
  always_comb begin
    if (32'(width_r) > 32'(MAX_WIDTH)) w_eff = COL_W'(MAX_WIDTH);
    else                               w_eff = COL_W'(width_r);
    if (32'(height_r) > 32'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    else                                 h_eff = HGT_W'(height_r);

    unique case (mode_r)
      MODE_1BPP:  bytes = (RBC_W'(w_eff) + RBC_W'(7)) >> 3;
      MODE_4BPP:  bytes = (RBC_W'(w_eff) + RBC_W'(1)) >> 1;
      MODE_8BPP:  bytes = RBC_W'(w_eff);
      MODE_24BPP: bytes = (RBC_W'(w_eff) << 1) + RBC_W'(w_eff);
      MODE_32BPP: bytes = RBC_W'(w_eff) << 2;
      default:    bytes = RBC_W'(w_eff);
    endcase
    line_pad  = (bytes + RBC_W'(3)) & ~RBC_W'(3);
    line      = (line_pad == '0) ? RBC_W'(4) : line_pad;
    line_done = ((RBC_W + 1)'(rbc_r) + (RBC_W + 1)'(1)) >= (RBC_W + 1)'(line);
    last_row  = (HGT_W'(row_r) + HGT_W'(1)) >= h_eff;
    left      = w_eff - col_r;

    // 24-bit mode restarts a group left over from 32-bit mode
    if (mode_r == MODE_24BPP && phase_r > 2'd2) p_eff = 2'd0;
    else                                        p_eff = phase_r;
    unique case (p_eff)
      2'd0:    b_sh = {16'd0, in_ch.data_byte};
      2'd1:    b_sh = {8'd0, in_ch.data_byte, 8'd0};
      2'd2:    b_sh = {in_ch.data_byte, 16'd0};
      default: b_sh = 24'd0;
    endcase
    g_new = gather_r | b_sh;
  end

  // Per-request update
  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    rbc_nxt    = rbc_r;
    gather_nxt = gather_r;
    phase_nxt  = phase_r;
    cnt        = '0;
    run_ld     = 1'b0;
    run_nxt    = '{op: OP_PIX1, cnt: '0, pal_idx: in_ch.pal_index,
                   data: {16'd0, in_ch.data_byte}, row_end: 1'b0, frame_end: 1'b0};

    if (acc) begin
      unique case (in_ch.cmd)
        CMD_DATA: begin
          if (mode_r <= MODE_32BPP) begin
            if (col_r < w_eff) begin
              unique case (mode_r)
                MODE_1BPP: begin
                  run_nxt.op = OP_PIX1;
                  cnt = (left < COL_W'(8)) ? CNT_W'(left) : CNT_W'(8);
                end
                MODE_4BPP: begin
                  run_nxt.op = OP_PIX4;
                  cnt = (left < COL_W'(2)) ? CNT_W'(left) : CNT_W'(2);
                end
                MODE_8BPP: begin
                  run_nxt.op = OP_PAL8;
                  cnt = CNT_W'(1);
                end
                MODE_24BPP: begin
                  run_nxt.op   = OP_DIRECT;
                  run_nxt.data = {g_new[7:0], g_new[15:8], g_new[23:16]};
                  if (p_eff == 2'd2) begin
                    cnt        = CNT_W'(1);
                    phase_nxt  = 2'd0;
                    gather_nxt = 24'd0;
                  end else begin
                    phase_nxt  = p_eff + 2'd1;
                    gather_nxt = g_new;
                  end
                end
                default: begin
                  run_nxt.op   = OP_DIRECT;
                  run_nxt.data = gather_r;
                  if (phase_r < 2'd3) begin
                    phase_nxt  = phase_r + 2'd1;
                    gather_nxt = g_new;
                  end else begin
                    cnt        = CNT_W'(1);
                    phase_nxt  = 2'd0;
                    gather_nxt = 24'd0;
                  end
                end
              endcase
              col_nxt = col_r + COL_W'(cnt);
            end
            run_nxt.cnt       = cnt;
            run_nxt.row_end   = (col_r + COL_W'(cnt)) == w_eff;
            run_nxt.frame_end = run_nxt.row_end && last_row;
            run_ld            = (cnt != '0);

            if (line_done) begin
              rbc_nxt    = '0;
              col_nxt    = '0;
              phase_nxt  = 2'd0;
              gather_nxt = 24'd0;
              row_nxt    = last_row ? '0 : row_r + ROW_W'(1);
            end else begin
              rbc_nxt = rbc_r + RBC_W'(1);
            end
          end
        end
        CMD_PAL: begin
          run_nxt.op   = OP_PALWR;
          run_nxt.data = {in_ch.pal_red, in_ch.pal_green, in_ch.pal_blue};
          run_ld       = 1'b1;
        end
        CMD_RESTART: begin
          col_nxt    = '0;
          row_nxt    = '0;
          rbc_nxt    = '0;
          gather_nxt = 24'd0;
          phase_nxt  = 2'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      rbc_r    <= '0;
      gather_r <= 24'd0;
      phase_r  <= 2'd0;
      run_v_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_MODE:   mode_r   <= cfg_ch.data[2:0];
          REG_WIDTH:  width_r  <= cfg_ch.data;
          REG_HEIGHT: height_r <= cfg_ch.data;
          default: ;
        endcase
      end
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      rbc_r    <= rbc_nxt;
      gather_r <= gather_nxt;
      phase_r  <= phase_nxt;
      if (run_ld)        run_v_r <= 1'b1;
      else if (run_take) run_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run_ld) run_r <= run_nxt;
  end

endmodule

### hw/rtl/dpu_expand.sv
// ----------------------------------------------------------------------------
// dpu_expand
// Steps a run one pixel per cycle unless stalled, reads the palette and holds
// the pixel in the output register. Palette writes apply in request order.
// ----------------------------------------------------------------------------
module dpu_expand (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          run_v,
  input  dpu_pkg::run_t run,
  output logic          run_take,
  dpu_out_if.source     out_ch
);
  import dpu_pkg::*;

  logic [23:0]       pal_mem [PAL_DEPTH];

  logic [SLOT_W-1:0] k_r;
  logic              p_v_r;
  pix_sel_t          p_sel_r, sel;
  logic [31:0]       p_word_r, word;
  logic [23:0]       p_pal_r;
  logic              p_eor_r, p_eof_r, p_last_r;

  logic              is_wr, last_slot, p_free, issue;
  logic [7:0]        rd_idx, byte_in;
  logic              rd_ok, wr_ok;

  assign byte_in   = run.data[7:0];
  assign is_wr     = (run.op == OP_PALWR);
  assign last_slot = (CNT_W'(k_r) + CNT_W'(1)) == run.cnt;
  assign p_free    = !p_v_r || out_ch.ready;
  assign issue     = run_v && !is_wr && p_free;
  assign run_take  = run_v && (is_wr || (p_free && last_slot));
  assign rd_ok     = 32'(rd_idx) < PAL_DEPTH;
  assign wr_ok     = 32'(run.pal_idx) < PAL_DEPTH;

  always_comb begin
    sel    = PS_WORD;
    word   = 32'd0;
    rd_idx = byte_in;
    unique case (run.op)
      OP_PIX1:   word = byte_in[k_r] ? 32'h0000_00FF : 32'd0;   // LSB first
      OP_PIX4: begin
        sel    = PS_PAL4;
        rd_idx = (k_r == '0) ? {4'd0, byte_in[7:4]} : {4'd0, byte_in[3:0]};
      end
      OP_PAL8:   sel  = PS_PAL8;
      OP_DIRECT: word = {run.data, 8'hFF};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= '0;
      p_v_r <= 1'b0;
    end else begin
      if (issue) k_r <= last_slot ? '0 : k_r + SLOT_W'(1);
      if (issue)             p_v_r <= 1'b1;
      else if (out_ch.ready) p_v_r <= 1'b0;
    end
  end

  // Palette memory and output register payload
  always_ff @(posedge clk) begin
    if (run_v && is_wr && wr_ok) pal_mem[run.pal_idx[PAL_AW-1:0]] <= run.data;
    if (issue) begin
      p_pal_r  <= rd_ok ? pal_mem[rd_idx[PAL_AW-1:0]] : 24'd0;
      p_sel_r  <= sel;
      p_word_r <= word;
      p_eor_r  <= last_slot && run.row_end;
      p_eof_r  <= last_slot && run.frame_end;
      p_last_r <= last_slot;
    end
  end

  always_comb begin
    unique case (p_sel_r)
      PS_PAL4: out_ch.pixel_word = {p_pal_r, 8'hFF};
      PS_PAL8: out_ch.pixel_word = {p_pal_r[7:0], p_pal_r[15:8], p_pal_r[23:16], 8'hFF};
      default: out_ch.pixel_word = p_word_r;
    endcase
  end

  assign out_ch.valid        = p_v_r;
  assign out_ch.end_of_row   = p_eor_r;
  assign out_ch.end_of_frame = p_eof_r;
  assign out_ch.last_of_run  = p_last_r;

`ifndef SYNTHESIS
  a_run_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    run_v && !is_wr |-> run.cnt != '0 && run.cnt <= CNT_W'(MAX_RUN))
    else $error("pixel run with bad count");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_v && !is_wr |-> CNT_W'(k_r) < run.cnt)
    else $error("slot counter ran past run");
  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r && p_eof_r |-> p_eor_r && p_last_r)
    else $error("frame end without row end");
  a_eor_last: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r && p_eor_r |-> p_last_r)
    else $error("row end inside a run");
  a_issue_out: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> p_v_r)
    else $error("issued pixel lost");
`endif

endmodule

### hw/rtl/dib_pixel_unpack_to_rgba.sv
// ----------------------------------------------------------------------------
// dib_pixel_unpack_to_rgba
// Unpacks padded bitmap rows (1/4/8/24/32 bpp) into 32-bit pixel words.
// ----------------------------------------------------------------------------
// Path: a request's first pixel passes the run register, then the output register.
// Throughput: one request per cycle while each yields at most one pixel and the
//   output is not stalled; a 1-bit byte yields up to 8 pixels and a 4-bit byte
//   up to 2, one pixel per cycle on the output register while it is not stalled.
//   Palette writes and padding bytes yield no pixels.
// Reset: counters clear, mode 24 bpp, 640 x 480; palette is not cleared.
module dib_pixel_unpack_to_rgba (
  input  logic      clk,
  input  logic      rst_n,
  dpu_in_if.sink    in_ch,
  dpu_cfg_if.sink   cfg_ch,
  dpu_out_if.source out_ch
);
  import dpu_pkg::*;

  // Run register between the unpacker and the expander: one descriptor per
  // request that makes pixels or writes the palette.
  logic run_v;
  logic run_take;
  run_t run;

  // Counters, byte gathering and config registers
  dpu_unpack u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .run_take (run_take),
    .run_v    (run_v),
    .run      (run)
  );

  // Pixel stepping, palette lookup and output register
  dpu_expand u_expand (
    .clk      (clk),
    .rst_n    (rst_n),
    .run_v    (run_v),
    .run      (run),
    .run_take (run_take),
    .out_ch   (out_ch)
  );

endmodule
